/* rtl/core/rcc_pkg.sv */
// Shared types, constants and the CRC step for the read-coils request checker.
// Used by the config channel interface and by every module of the block; depends on nothing.
package rcc_pkg;

    // Frame layout
    localparam int FRAME_BYTES = 8;
    localparam int IDX_W       = $clog2(FRAME_BYTES);

    localparam logic [IDX_W-1:0] BYTE_SLAVE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] BYTE_FCODE   = IDX_W'(1);
    localparam logic [IDX_W-1:0] BYTE_ADDR_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] BYTE_ADDR_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] BYTE_QTY_HI  = IDX_W'(4);
    localparam logic [IDX_W-1:0] BYTE_QTY_LO  = IDX_W'(5);
    localparam logic [IDX_W-1:0] BYTE_CRC_LO  = IDX_W'(FRAME_BYTES - 2);
    localparam logic [IDX_W-1:0] BYTE_CRC_HI  = IDX_W'(FRAME_BYTES - 1);

    // Modbus CRC-16: reflected polynomial, all-ones start, no final xor
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // Configuration port
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_QUANTITY_MIN = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_QUANTITY_MAX = CFG_INDEX_W'(1);

    localparam logic [15:0] QUANTITY_MIN_RESET = 16'd1;
    localparam logic [15:0] QUANTITY_MAX_RESET = 16'd2000;

    // Completed frame, handed from the parser to the result stage
    typedef struct packed {
        logic        done;
        logic [7:0]  slave_addr;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic        crc_ok;
    } frame_t;

    // One result held in the output buffer
    typedef struct packed {
        logic [7:0]  slave_addr;
        logic [7:0]  function_code;
        logic [15:0] start_address;
        logic [15:0] quantity;
        logic        crc_ok;
        logic        quantity_ok;
        logic        frame_ok;
    } result_t;

    // Advance the CRC by one byte, least significant bit first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* rtl/core/rcc_if.sv */
// Valid/ready channel interfaces of the read-coils request checker.
// Depends on rcc_pkg for field widths.
interface rcc_req_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       frame_start;

    modport source (output valid, output rx_byte, output frame_start, input ready);
    modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface rcc_res_if;
    logic        valid;
    logic        ready;
    logic [7:0]  slave_addr;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] quantity;
    logic        crc_ok;
    logic        quantity_ok;
    logic        frame_ok;

    modport source (output valid, output slave_addr, output function_code,
                    output start_address, output quantity, output crc_ok,
                    output quantity_ok, output frame_ok, input ready);
    modport sink   (input valid, input slave_addr, input function_code,
                    input start_address, input quantity, input crc_ok,
                    input quantity_ok, input frame_ok, output ready);
endinterface

interface rcc_cfg_if;
    import rcc_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/rcc_frame_parse.sv */
// Byte parser: tracks the byte position, runs the CRC and captures the request fields.
// Depends on rcc_pkg and rcc_if.
module rcc_frame_parse (
    input  logic            clk,
    input  logic            rst_n,
    rcc_req_if.sink         req,
    input  logic            space,
    output rcc_pkg::frame_t frame
);
    import rcc_pkg::*;

    logic [IDX_W-1:0] byte_index_reg, byte_index_next;
    logic [15:0]      crc_reg, crc_next;
    logic [7:0]       slave_reg, fcode_reg, crc_low_reg;
    logic [15:0]      address_reg, quantity_reg;

    logic             take;
    logic [IDX_W-1:0] idx;
    logic [15:0]      crc_base;

    assign req.ready = space;
    assign take      = req.valid && space;

    // frame_start restarts position and CRC before the byte is taken
    assign idx      = req.frame_start ? BYTE_SLAVE : byte_index_reg;
    assign crc_base = req.frame_start ? CRC_INIT : crc_reg;

    always_comb
    begin
        byte_index_next = byte_index_reg;
        crc_next        = crc_reg;
        if (take)
        begin
            if (idx == BYTE_CRC_HI)
            begin
                byte_index_next = BYTE_SLAVE;
                crc_next        = CRC_INIT;
            end
            else
            begin
                byte_index_next = idx + IDX_W'(1);
                if (idx < BYTE_CRC_LO)
                    crc_next = crc16_byte(crc_base, req.rx_byte);
                else
                    crc_next = crc_base;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_index_reg <= BYTE_SLAVE;
            crc_reg        <= CRC_INIT;
            slave_reg      <= 8'h00;
            fcode_reg      <= 8'h00;
            address_reg    <= 16'h0000;
            quantity_reg   <= 16'h0000;
            crc_low_reg    <= 8'h00;
        end
        else
        begin
            byte_index_reg <= byte_index_next;
            crc_reg        <= crc_next;
            if (take)
            begin
                case (idx)
                    BYTE_SLAVE:   slave_reg          <= req.rx_byte;
                    BYTE_FCODE:   fcode_reg          <= req.rx_byte;
                    BYTE_ADDR_HI: address_reg[15:8]  <= req.rx_byte;
                    BYTE_ADDR_LO: address_reg[7:0]   <= req.rx_byte;
                    BYTE_QTY_HI:  quantity_reg[15:8] <= req.rx_byte;
                    BYTE_QTY_LO:  quantity_reg[7:0]  <= req.rx_byte;
                    BYTE_CRC_LO:  crc_low_reg        <= req.rx_byte;
                    default:      ;
                endcase
            end
        end
    end

    // Last byte: CRC arrives low byte first, so it is the high half here
    always_comb
    begin
        frame.done          = take && (idx == BYTE_CRC_HI);
        frame.slave_addr    = slave_reg;
        frame.function_code = fcode_reg;
        frame.start_address = address_reg;
        frame.quantity      = quantity_reg;
        frame.crc_ok        = ({req.rx_byte, crc_low_reg} == crc_base);
    end

    a_wrap_to_start: assert property (@(posedge clk) disable iff (!rst_n)
        frame.done |=> byte_index_reg == BYTE_SLAVE)
        else $error("byte position did not wrap after the last byte");

    a_crc_fresh_at_start: assert property (@(posedge clk) disable iff (!rst_n)
        byte_index_reg == BYTE_SLAVE |-> crc_reg == CRC_INIT)
        else $error("CRC not at its start value at the first byte");

endmodule

/* rtl/core/rcc_cfg_regs.sv */
// Configuration registers: quantity bounds written through the config channel.
// Depends on rcc_pkg and rcc_if.
module rcc_cfg_regs (
    input  logic        clk,
    input  logic        rst_n,
    rcc_cfg_if.sink     cfg,
    output logic [15:0] quantity_min,
    output logic [15:0] quantity_max
);
    import rcc_pkg::*;

    logic [15:0] qmin_reg, qmax_reg;
    logic        wr;

    assign cfg.ready = 1'b1;
    assign wr        = cfg.valid;

    // Unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qmin_reg <= QUANTITY_MIN_RESET;
            qmax_reg <= QUANTITY_MAX_RESET;
        end
        else if (wr)
        begin
            case (cfg.index)
                REG_QUANTITY_MIN: qmin_reg <= cfg.data;
                REG_QUANTITY_MAX: qmax_reg <= cfg.data;
                default:          ;
            endcase
        end
    end

    assign quantity_min = qmin_reg;
    assign quantity_max = qmax_reg;

endmodule

/* rtl/core/rcc_result_stage.sv */
// Result stage: bound check, flags and a two-entry output buffer (register plus skid).
// Depends on rcc_pkg and rcc_if.
module rcc_result_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  rcc_pkg::frame_t frame,
    input  logic [15:0]     quantity_min,
    input  logic [15:0]     quantity_max,
    output logic            space,
    rcc_res_if.source       res
);
    import rcc_pkg::*;

    result_t new_res;
    result_t out_reg, skid_reg;
    logic    out_valid_reg, skid_valid_reg;
    logic    pop;

    always_comb
    begin
        new_res.slave_addr    = frame.slave_addr;
        new_res.function_code = frame.function_code;
        new_res.start_address = frame.start_address;
        new_res.quantity      = frame.quantity;
        new_res.crc_ok        = frame.crc_ok;
        new_res.quantity_ok   = (frame.quantity >= quantity_min) &&
                                (frame.quantity <= quantity_max);
        new_res.frame_ok      = frame.crc_ok && new_res.quantity_ok;
    end

    assign pop   = out_valid_reg && res.ready;
    assign space = !skid_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_reg  <= skid_valid_reg || frame.done;
            skid_valid_reg <= 1'b0;
        end
        else if (frame.done)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    // Payload: refill the output from the skid first, else from the new frame
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
                out_reg <= skid_reg;
            else
                out_reg <= new_res;
        end
        else if (frame.done)
        begin
            skid_reg <= new_res;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.slave_addr    = out_reg.slave_addr;
    assign res.function_code = out_reg.function_code;
    assign res.start_address = out_reg.start_address;
    assign res.quantity      = out_reg.quantity;
    assign res.crc_ok        = out_reg.crc_ok;
    assign res.quantity_ok   = out_reg.quantity_ok;
    assign res.frame_ok      = out_reg.frame_ok;

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a result while the output register is empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(frame.done && skid_valid_reg))
        else $error("frame completed with the output buffer full");

    a_flags_agree: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.frame_ok == (out_reg.crc_ok && out_reg.quantity_ok))
        else $error("frame_ok disagrees with crc_ok and quantity_ok");

endmodule

/* rtl/core/read_coils_request_checker.sv */
// Top level of the read-coils request checker.
// Depends on rcc_pkg, rcc_if, rcc_frame_parse, rcc_cfg_regs and rcc_result_stage.
//
// The block takes one byte of a fixed 8-byte Modbus read-coils request per
// request on req (slave, function code, start address high/low, quantity
// high/low, CRC low/high) and runs the Modbus CRC-16 over the first six bytes.
// A byte is taken in every cycle with req.ready high: the CRC step for one byte
// and the field capture are done as it is taken, so sustained rate is one byte per clock.
// frame_start on a byte restarts the frame at that byte; after the eighth
// byte the next byte opens a new frame on its own. The eighth byte produces
// one registered result on res, carrying the decoded fields, crc_ok,
// quantity_ok (quantity_min <= quantity <= quantity_max) and frame_ok; all
// other bytes produce nothing. Results sit in a two-entry buffer (output
// register plus skid), so req.ready drops only when both entries hold
// results that res has not taken. Bounds are written through cfg (index 0:
// quantity_min, reset 1; index 1: quantity_max, reset 2000; other indexes
// are dropped); cfg.ready is always high, and bounds should change only
// while no frame is in flight.
module read_coils_request_checker (
    input logic       clk,
    input logic       rst_n,
    rcc_req_if.sink   req,
    rcc_res_if.source res,
    rcc_cfg_if.sink   cfg
);
    import rcc_pkg::*;

    frame_t      frame;
    logic        space;
    logic [15:0] quantity_min;
    logic [15:0] quantity_max;

    // Track position, CRC and fields; flag the completed frame
    rcc_frame_parse u_parse (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .space (space),
        .frame (frame)
    );

    // Hold the quantity bounds
    rcc_cfg_regs u_cfg (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .quantity_min (quantity_min),
        .quantity_max (quantity_max)
    );

    // Check bounds, form the flags and buffer the result
    rcc_result_stage u_result (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame        (frame),
        .quantity_min (quantity_min),
        .quantity_max (quantity_max),
        .space        (space),
        .res          (res)
    );

endmodule
